// File: rtl/packet_descriptor_seek_buffer_assert.svh
// Assertion helpers for the seek buffer.
`ifndef PACKET_DESCRIPTOR_SEEK_BUFFER_ASSERT_SVH
`define PACKET_DESCRIPTOR_SEEK_BUFFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pdsb_pkg.sv
package pdsb_pkg;

  // Field widths
  localparam int CW  = 7;   // count, position, walk index
  localparam int TSW = 48;  // 32.16 timestamp
  localparam int LW  = 32;  // 16.16 duration
  localparam int SW  = 24;  // byte size
  localparam int TTW = 40;  // duration totals
  localparam int TBW = 32;  // byte totals

  localparam logic [LW-1:0] KEEP_RST = 32'd655360;

  // Transaction modes
  localparam logic [2:0] MODE_PUT   = 3'd0;
  localparam logic [2:0] MODE_FETCH = 3'd1;
  localparam logic [2:0] MODE_SEEK  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_ITER  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Read address sources (logical index)
  localparam logic [2:0] RS_POS  = 3'd0;
  localparam logic [2:0] RS_IDX  = 3'd1;
  localparam logic [2:0] RS_PM1  = 3'd2;
  localparam logic [2:0] RS_ZERO = 3'd3;
  localparam logic [2:0] RS_LAST = 3'd4;

  // Walk index load sources
  localparam logic [1:0] IS_POS      = 2'd0;
  localparam logic [1:0] IS_PM1      = 2'd1;
  localparam logic [1:0] IS_FOUND    = 2'd2;
  localparam logic [1:0] IS_FOUND_M1 = 2'd3;

  typedef struct packed {
    logic [2:0]     mode;
    logic [TSW-1:0] time_stamp;
    logic [LW-1:0]  length_time;
    logic [SW-1:0]  byte_size;
    logic           key_frame;
    logic           snap_backward;
  } item_t;

  typedef struct packed {
    logic [TSW-1:0] ts;
    logic [LW-1:0]  len;
    logic [SW-1:0]  size;
    logic           key;
  } entry_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [TSW-1:0] out_time_stamp;
    logic [LW-1:0]  out_length_time;
    logic [SW-1:0]  out_byte_size;
    logic           out_key_frame;
    logic [TTW-1:0] ahead_time;
    logic [TTW-1:0] behind_time;
    logic [TBW-1:0] ahead_bytes;
    logic [TBW-1:0] behind_bytes;
    logic [CW-1:0]  read_position;
    logic [CW-1:0]  entry_count;
    logic           last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd;
    logic [2:0] rd_src;
    logic       clear;
    logic       trim;
    logic       append;
    logic       fetch;
    logic       backs_ld;
    logic       first_ld;
    logic       clamp;
    logic       idx_ld;
    logic [1:0] idx_src;
    logic       idx_inc;
    logic       idx_dec;
    logic       acc_add;
    logic       acc_sub;
    logic       found_ld;
    logic       commit;
    logic       emit;
    logic [1:0] em_status;
    logic       em_has;
    logic       em_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       snap;
    logic       count_zero;
    logic       pos_ge_count;
    logic       full;
    logic       trim_go;
    logic       backs;
    logic       clamp_fail;
    logic       idx_ge_count;
    logic       idx_zero;
    logic       idx_last;
    logic       found_zero;
    logic       rd_ge;
    logic       rd_le;
    logic       rd_key;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/pdsb_in_if.sv
interface pdsb_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic [pdsb_pkg::TSW-1:0]  time_stamp;
  logic [pdsb_pkg::LW-1:0]   length_time;
  logic [pdsb_pkg::SW-1:0]   byte_size;
  logic                      key_frame;
  logic                      snap_backward;

  modport source (output valid, mode, time_stamp, length_time, byte_size, key_frame,
                  snap_backward, input ready);
  modport sink (input valid, mode, time_stamp, length_time, byte_size, key_frame,
                snap_backward, output ready);
endinterface

// File: rtl/pdsb_out_if.sv
interface pdsb_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [pdsb_pkg::TSW-1:0]  out_time_stamp;
  logic [pdsb_pkg::LW-1:0]   out_length_time;
  logic [pdsb_pkg::SW-1:0]   out_byte_size;
  logic                      out_key_frame;
  logic [pdsb_pkg::TTW-1:0]  ahead_time;
  logic [pdsb_pkg::TTW-1:0]  behind_time;
  logic [pdsb_pkg::TBW-1:0]  ahead_bytes;
  logic [pdsb_pkg::TBW-1:0]  behind_bytes;
  logic [pdsb_pkg::CW-1:0]   read_position;
  logic [pdsb_pkg::CW-1:0]   entry_count;
  logic                      last;

  modport source (output valid, status, out_time_stamp, out_length_time, out_byte_size,
                  out_key_frame, ahead_time, behind_time, ahead_bytes, behind_bytes,
                  read_position, entry_count, last, input ready);
  modport sink (input valid, status, out_time_stamp, out_length_time, out_byte_size,
                out_key_frame, ahead_time, behind_time, ahead_bytes, behind_bytes,
                read_position, entry_count, last, output ready);
endinterface

// File: rtl/pdsb_dpath.sv
module pdsb_dpath #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pdsb_pkg::item_t   in_item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  pdsb_pkg::cmd_t    cmd,
  output pdsb_pkg::sts_t    sts,
  input  logic              out_ready,
  output logic              out_valid,
  output pdsb_pkg::result_t out_res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = pdsb_pkg::CW;

  // Logical index to ring slot
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] l);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, head} + {1'b0, l};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  pdsb_pkg::entry_t mem [DEPTH];
  pdsb_pkg::entry_t rd_q_r;
  pdsb_pkg::item_t  item_r;
  pdsb_pkg::result_t res_r;

  logic [AW-1:0]            head_r;
  logic [CW-1:0]            count_r, pos_r, idx_r, found_r;
  logic [pdsb_pkg::TTW-1:0] at_r, bt_r, dt_r;
  logic [pdsb_pkg::TBW-1:0] ab_r, bb_r, db_r;
  logic [pdsb_pkg::LW-1:0]  keep_r;
  logic [pdsb_pkg::TSW-1:0] tgt_r, first_r;
  logic                     backs_r, out_valid_r;

  logic [CW-1:0]            rd_log, idx_load;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [pdsb_pkg::TTW-1:0] len_x;
  logic [pdsb_pkg::TBW-1:0] size_x;
  logic [pdsb_pkg::TSW-1:0] first_floor, last_ts, clamp_tgt;
  logic [pdsb_pkg::TSW:0]   last_ceil;
  logic                     clamp_fail;

  assign len_x  = {{(pdsb_pkg::TTW-pdsb_pkg::LW){1'b0}}, rd_q_r.len};
  assign size_x = {{(pdsb_pkg::TBW-pdsb_pkg::SW){1'b0}}, rd_q_r.size};

  // Read address select
  always_comb begin
    case (cmd.rd_src)
      pdsb_pkg::RS_POS:  rd_log = pos_r;
      pdsb_pkg::RS_IDX:  rd_log = idx_r;
      pdsb_pkg::RS_PM1:  rd_log = pos_r - 1'b1;
      pdsb_pkg::RS_LAST: rd_log = count_r - 1'b1;
      default:           rd_log = '0;
    endcase
  end
  assign rd_addr = slot_of(head_r, rd_log);
  assign wr_addr = slot_of(head_r, count_r);

  // Walk index load select
  always_comb begin
    case (cmd.idx_src)
      pdsb_pkg::IS_POS:   idx_load = pos_r;
      pdsb_pkg::IS_PM1:   idx_load = pos_r - 1'b1;
      pdsb_pkg::IS_FOUND: idx_load = found_r;
      default:            idx_load = found_r - 1'b1;
    endcase
  end

  // Seek end clamping: first entry in first_r, last entry in the read register
  always_comb begin
    last_ts     = rd_q_r.ts;
    first_floor = {first_r[pdsb_pkg::TSW-1:16], 16'h0000};
    last_ceil   = {1'b0, last_ts} + {{(pdsb_pkg::TSW-15){1'b0}}, 16'hFFFF};
    last_ceil[15:0] = 16'h0000;
    clamp_fail  = 1'b0;
    clamp_tgt   = tgt_r;
    if (backs_r && first_r > tgt_r) begin
      clamp_fail = first_floor > tgt_r;
      clamp_tgt  = first_r;
    end else if (!backs_r && last_ts < tgt_r) begin
      clamp_fail = last_ceil < {1'b0, tgt_r};
      clamp_tgt  = last_ts;
    end
  end

  // Status to controller
  always_comb begin
    sts.mode         = item_r.mode;
    sts.snap         = item_r.snap_backward;
    sts.count_zero   = count_r == '0;
    sts.pos_ge_count = pos_r >= count_r;
    sts.full         = count_r >= CW'(DEPTH);
    sts.trim_go      = (bt_r > {{(pdsb_pkg::TTW-pdsb_pkg::LW){1'b0}}, keep_r})
                       && (pos_r != '0);
    sts.backs        = backs_r;
    sts.clamp_fail   = clamp_fail;
    sts.idx_ge_count = idx_r >= count_r;
    sts.idx_zero     = idx_r == '0;
    sts.idx_last     = (idx_r + 1'b1) == count_r;
    sts.found_zero   = found_r == '0;
    sts.rd_ge        = rd_q_r.ts >= tgt_r;
    sts.rd_le        = rd_q_r.ts <= tgt_r;
    sts.rd_key       = rd_q_r.key;
    sts.out_free     = !out_valid_r || out_ready;
  end

  // Descriptor store
  always_ff @(posedge clk) begin
    if (cmd.append && !sts.full) begin
      mem[wr_addr] <= '{ts: item_r.time_stamp, len: item_r.length_time,
                        size: item_r.byte_size, key: item_r.key_frame};
    end
    if (cmd.rd) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Buffer state and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      at_r        <= '0;
      bt_r        <= '0;
      ab_r        <= '0;
      bb_r        <= '0;
      keep_r      <= pdsb_pkg::KEEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        head_r  <= '0;
        count_r <= '0;
        pos_r   <= '0;
        at_r    <= '0;
        bt_r    <= '0;
        ab_r    <= '0;
        bb_r    <= '0;
      end else if (cmd.trim) begin
        head_r  <= (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_r <= count_r - 1'b1;
        pos_r   <= pos_r - 1'b1;
        bt_r    <= bt_r - len_x;
        bb_r    <= bb_r - size_x;
      end else if (cmd.append && !sts.full) begin
        count_r <= count_r + 1'b1;
        at_r    <= at_r + {{(pdsb_pkg::TTW-pdsb_pkg::LW){1'b0}}, item_r.length_time};
        ab_r    <= ab_r + {{(pdsb_pkg::TBW-pdsb_pkg::SW){1'b0}}, item_r.byte_size};
      end else if (cmd.fetch) begin
        pos_r <= pos_r + 1'b1;
        at_r  <= at_r - len_x;
        bt_r  <= bt_r + len_x;
        ab_r  <= ab_r - size_x;
        bb_r  <= bb_r + size_x;
      end else if (cmd.commit) begin
        pos_r <= found_r;
        at_r  <= at_r - dt_r;
        bt_r  <= bt_r + dt_r;
        ab_r  <= ab_r - db_r;
        bb_r  <= bb_r + db_r;
      end
      // Result register
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction fields, seek walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      tgt_r  <= in_item.time_stamp;
    end else if (cmd.clamp) begin
      tgt_r <= clamp_tgt;
    end
    if (cmd.backs_ld) begin
      backs_r <= (pos_r != '0) && (tgt_r < rd_q_r.ts);
    end
    if (cmd.first_ld) begin
      first_r <= rd_q_r.ts;
    end
    if (cmd.idx_ld) begin
      idx_r <= idx_load;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.found_ld) begin
      found_r <= idx_r;
    end
    if (cmd.clamp) begin
      dt_r <= '0;
      db_r <= '0;
    end else if (cmd.acc_add) begin
      dt_r <= dt_r + len_x;
      db_r <= db_r + size_x;
    end else if (cmd.acc_sub) begin
      dt_r <= dt_r - len_x;
      db_r <= db_r - size_x;
    end
    if (cmd.emit) begin
      res_r.status          <= cmd.em_status;
      res_r.out_time_stamp  <= cmd.em_has ? rd_q_r.ts : '0;
      res_r.out_length_time <= cmd.em_has ? rd_q_r.len : '0;
      res_r.out_byte_size   <= cmd.em_has ? rd_q_r.size : '0;
      res_r.out_key_frame   <= cmd.em_has ? rd_q_r.key : 1'b0;
      res_r.ahead_time      <= at_r;
      res_r.behind_time     <= bt_r;
      res_r.ahead_bytes     <= ab_r;
      res_r.behind_bytes    <= bb_r;
      res_r.read_position   <= pos_r;
      res_r.entry_count     <= count_r;
      res_r.last            <= cmd.em_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/pdsb_ctrl.sv
module pdsb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pdsb_pkg::sts_t sts,
  output pdsb_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_PT_CHK  = 5'd2;
  localparam logic [4:0] S_PT_SUB  = 5'd3;
  localparam logic [4:0] S_PT_WR   = 5'd4;
  localparam logic [4:0] S_F_UPD   = 5'd5;
  localparam logic [4:0] S_SK_B    = 5'd6;
  localparam logic [4:0] S_SK_F    = 5'd7;
  localparam logic [4:0] S_SK_L    = 5'd8;
  localparam logic [4:0] S_WF_RD   = 5'd9;
  localparam logic [4:0] S_WF_CHK  = 5'd10;
  localparam logic [4:0] S_WB_RD   = 5'd11;
  localparam logic [4:0] S_WB_CHK  = 5'd12;
  localparam logic [4:0] S_K_CHK   = 5'd13;
  localparam logic [4:0] S_COMMIT  = 5'd14;
  localparam logic [4:0] S_IT_BRD  = 5'd15;
  localparam logic [4:0] S_IT_BCHK = 5'd16;
  localparam logic [4:0] S_IT_FRD  = 5'd17;
  localparam logic [4:0] S_IT_FCHK = 5'd18;
  localparam logic [4:0] S_IT_EMIT = 5'd19;
  localparam logic [4:0] S_IT_RD   = 5'd20;
  localparam logic [4:0] S_EMIT    = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic [1:0] em_st_r, em_st_nxt;
  logic       em_has_r, em_has_nxt;
  logic       kon_r, kon_nxt;  // second walk: keyframes only

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      em_st_r  <= pdsb_pkg::ST_OK;
      em_has_r <= 1'b0;
      kon_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      em_st_r  <= em_st_nxt;
      em_has_r <= em_has_nxt;
      kon_r    <= kon_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    em_st_nxt  = em_st_r;
    em_has_nxt = em_has_r;
    kon_nxt    = kon_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      // Decode the latched transaction
      S_DISP: begin
        em_has_nxt = 1'b0;
        state_nxt  = S_EMIT;
        em_st_nxt  = pdsb_pkg::ST_FAIL;
        case (sts.mode)
          pdsb_pkg::MODE_PUT: begin
            state_nxt = S_PT_CHK;
          end
          pdsb_pkg::MODE_FETCH: begin
            if (!sts.pos_ge_count) begin
              cmd.rd     = 1'b1;
              cmd.rd_src = pdsb_pkg::RS_POS;
              state_nxt  = S_F_UPD;
            end
          end
          pdsb_pkg::MODE_SEEK: begin
            if (!sts.count_zero) begin
              cmd.rd     = 1'b1;
              cmd.rd_src = pdsb_pkg::RS_PM1;
              state_nxt  = S_SK_B;
            end
          end
          pdsb_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
            em_st_nxt = pdsb_pkg::ST_OK;
          end
          pdsb_pkg::MODE_ITER: begin
            if (sts.pos_ge_count) begin
              em_st_nxt = pdsb_pkg::ST_NONE;
            end else begin
              cmd.idx_ld  = 1'b1;
              cmd.idx_src = pdsb_pkg::IS_POS;
              state_nxt   = S_IT_BRD;
            end
          end
          default: begin
          end
        endcase
      end
      // Put: trim played entries, then append
      S_PT_CHK: begin
        if (sts.trim_go) begin
          cmd.rd     = 1'b1;
          cmd.rd_src = pdsb_pkg::RS_ZERO;
          state_nxt  = S_PT_SUB;
        end else begin
          state_nxt = S_PT_WR;
        end
      end
      S_PT_SUB: begin
        cmd.trim  = 1'b1;
        state_nxt = S_PT_CHK;
      end
      S_PT_WR: begin
        cmd.append = 1'b1;
        em_st_nxt  = sts.full ? pdsb_pkg::ST_FAIL : pdsb_pkg::ST_OK;
        state_nxt  = S_EMIT;
      end
      // Fetch: entry is in the read register
      S_F_UPD: begin
        cmd.fetch  = 1'b1;
        em_st_nxt  = pdsb_pkg::ST_OK;
        em_has_nxt = 1'b1;
        state_nxt  = S_EMIT;
      end
      // Seek: direction, then first and last timestamps
      S_SK_B: begin
        cmd.backs_ld = 1'b1;
        cmd.rd       = 1'b1;
        cmd.rd_src   = pdsb_pkg::RS_ZERO;
        state_nxt    = S_SK_F;
      end
      S_SK_F: begin
        cmd.first_ld = 1'b1;
        cmd.rd       = 1'b1;
        cmd.rd_src   = pdsb_pkg::RS_LAST;
        state_nxt    = S_SK_L;
      end
      S_SK_L: begin
        if (sts.clamp_fail) begin
          em_st_nxt = pdsb_pkg::ST_FAIL;
          state_nxt = S_EMIT;
        end else begin
          cmd.clamp  = 1'b1;
          cmd.idx_ld = 1'b1;
          kon_nxt    = 1'b0;
          if (sts.backs) begin
            cmd.idx_src = pdsb_pkg::IS_PM1;
            state_nxt   = S_WB_RD;
          end else begin
            cmd.idx_src = pdsb_pkg::IS_POS;
            state_nxt   = S_WF_RD;
          end
        end
      end
      // Forward walk
      S_WF_RD: begin
        if (sts.idx_ge_count) begin
          em_st_nxt = pdsb_pkg::ST_FAIL;
          state_nxt = S_EMIT;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_src = pdsb_pkg::RS_IDX;
          state_nxt  = S_WF_CHK;
        end
      end
      S_WF_CHK: begin
        if (sts.rd_ge && (!kon_r || sts.rd_key)) begin
          cmd.found_ld = 1'b1;
          state_nxt    = kon_r ? S_COMMIT : S_K_CHK;
        end else begin
          cmd.acc_add = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WF_RD;
        end
      end
      // Backward walk
      S_WB_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = pdsb_pkg::RS_IDX;
        state_nxt  = S_WB_CHK;
      end
      S_WB_CHK: begin
        cmd.acc_sub = 1'b1;
        if (sts.rd_le && (!kon_r || sts.rd_key)) begin
          cmd.found_ld = 1'b1;
          state_nxt    = kon_r ? S_COMMIT : S_K_CHK;
        end else if (sts.idx_zero) begin
          em_st_nxt = pdsb_pkg::ST_FAIL;
          state_nxt = S_EMIT;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_WB_RD;
        end
      end
      // Match found: snap to a keyframe if needed
      S_K_CHK: begin
        if (sts.rd_key) begin
          cmd.commit = 1'b1;
          em_st_nxt  = pdsb_pkg::ST_OK;
          state_nxt  = S_EMIT;
        end else begin
          kon_nxt = 1'b1;
          if (!sts.snap) begin
            cmd.idx_ld  = 1'b1;
            cmd.idx_src = pdsb_pkg::IS_FOUND;
            state_nxt   = S_WF_RD;
          end else if (sts.found_zero) begin
            em_st_nxt = pdsb_pkg::ST_FAIL;
            state_nxt = S_EMIT;
          end else begin
            cmd.idx_ld  = 1'b1;
            cmd.idx_src = pdsb_pkg::IS_FOUND_M1;
            state_nxt   = S_WB_RD;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        em_st_nxt  = pdsb_pkg::ST_OK;
        state_nxt  = S_EMIT;
      end
      // Iterate: look back for a keyframe at or before the position
      S_IT_BRD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = pdsb_pkg::RS_IDX;
        state_nxt  = S_IT_BCHK;
      end
      S_IT_BCHK: begin
        if (sts.rd_key) begin
          state_nxt = S_IT_EMIT;
        end else if (sts.idx_zero) begin
          cmd.idx_ld  = 1'b1;
          cmd.idx_src = pdsb_pkg::IS_POS;
          state_nxt   = S_IT_FRD;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_IT_BRD;
        end
      end
      // None behind: first keyframe after the position
      S_IT_FRD: begin
        if (sts.idx_ge_count) begin
          em_st_nxt  = pdsb_pkg::ST_NONE;
          em_has_nxt = 1'b0;
          state_nxt  = S_EMIT;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_src = pdsb_pkg::RS_IDX;
          state_nxt  = S_IT_FCHK;
        end
      end
      S_IT_FCHK: begin
        if (sts.rd_key) begin
          state_nxt = S_IT_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_IT_FRD;
        end
      end
      // Emit entries through to the end
      S_IT_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em_status = pdsb_pkg::ST_OK;
          cmd.em_has    = 1'b1;
          cmd.em_last   = sts.idx_last;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_IT_RD;
          end
        end
      end
      S_IT_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = pdsb_pkg::RS_IDX;
        state_nxt  = S_IT_EMIT;
      end
      // Single result of the transaction
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em_status = em_st_r;
          cmd.em_has    = em_has_r;
          cmd.em_last   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/packet_descriptor_seek_buffer.sv
// Ring buffer of up to DEPTH media packet descriptors with a read position and
// running duration and byte totals before and after it. One transaction is
// handled at a time; the descriptor store is a single memory with one
// registered read port, so each entry visited is read in one state and used
// in the next. A waiting result in the output register does not keep the
// next transaction out.
// The store needs no clearing pass after reset.
`include "packet_descriptor_seek_buffer_assert.svh"

module packet_descriptor_seek_buffer #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pdsb_in_if.sink     in_ch,
  pdsb_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  pdsb_pkg::item_t   item;
  pdsb_pkg::result_t res;
  pdsb_pkg::cmd_t    cmd;
  pdsb_pkg::sts_t    sts;
  logic              in_ready;
  logic              out_valid;

  // Input transaction payload
  assign item = '{mode: in_ch.mode, time_stamp: in_ch.time_stamp,
                  length_time: in_ch.length_time, byte_size: in_ch.byte_size,
                  key_frame: in_ch.key_frame, snap_backward: in_ch.snap_backward};
  assign in_ch.ready = in_ready;

  pdsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdsb_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  // Result transaction
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = res.status;
  assign out_ch.out_time_stamp  = res.out_time_stamp;
  assign out_ch.out_length_time = res.out_length_time;
  assign out_ch.out_byte_size   = res.out_byte_size;
  assign out_ch.out_key_frame   = res.out_key_frame;
  assign out_ch.ahead_time      = res.ahead_time;
  assign out_ch.behind_time     = res.behind_time;
  assign out_ch.ahead_bytes     = res.ahead_bytes;
  assign out_ch.behind_bytes    = res.behind_bytes;
  assign out_ch.read_position   = res.read_position;
  assign out_ch.entry_count     = res.entry_count;
  assign out_ch.last            = res.last;

  `PDSB_ASSERT_NOW(a_count_bound, out_ch.valid, out_ch.entry_count <= pdsb_pkg::CW'(DEPTH), "entry count above depth")
  `PDSB_ASSERT_NOW(a_pos_bound, out_ch.valid, out_ch.read_position <= out_ch.entry_count, "position past entry count")
  `PDSB_ASSERT_NOW(a_none_last, out_ch.valid && out_ch.status == pdsb_pkg::ST_NONE, out_ch.last, "empty iterate not marked last")
  `PDSB_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready && !cmd.emit, "accepted while busy")

endmodule
